>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hec_pkg.sv
// ---------------------------------------------------------------------------
// hec_pkg
// Widths, codes, pipeline payload types and code-layout functions.
// ---------------------------------------------------------------------------
package hec_pkg;

  localparam int DATA_W        = 57;
  localparam int CODE_W        = 63;
  localparam int SYN_W         = 6;
  localparam int LEN_W         = 6;
  localparam int PAR_W         = 3;
  localparam int MAX_CODE_BITS = 63;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd4;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_CHECK  = 1'b1;

  // Smallest r with 2^r >= m + r + 1.
  function automatic logic [PAR_W-1:0] parity_count(input logic [LEN_W-1:0] m);
    logic [PAR_W-1:0] r;
    r = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if ((7'd1 << i) >= ({1'b0, m} + 7'(i) + 7'd1)) begin
        r = PAR_W'(i);
      end
    end
    return r;
  endfunction

  // Largest data length whose code still fits in MAX_CODE_BITS.
  function automatic int max_data();
    int best;
    best = 1;
    for (int m = 1; m < (1 << LEN_W); m++) begin
      if (m + int'(parity_count(LEN_W'(m))) <= MAX_CODE_BITS) begin
        best = m;
      end
    end
    return best;
  endfunction

  localparam int MAX_DATA = max_data();

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] m;
    m = len;
    if (len == '0) begin
      m = LEN_W'(1);
    end else if (int'(len) > MAX_DATA) begin
      m = LEN_W'(MAX_DATA);
    end
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] data_mask(input logic [LEN_W-1:0] m);
    logic [DATA_W-1:0] mask;
    for (int i = 0; i < DATA_W; i++) begin
      mask[i] = (i < int'(m));
    end
    return mask;
  endfunction

  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] m);
    logic [CODE_W-1:0] mask;
    int                n;
    n = int'(m) + int'(parity_count(m));
    for (int i = 0; i < CODE_W; i++) begin
      mask[i] = (i < n);
    end
    return mask;
  endfunction

  // Place data bits, LSB first, at the non-power-of-two positions.
  function automatic logic [CODE_W-1:0] scatter(input logic [DATA_W-1:0] data);
    logic [CODE_W-1:0] cw;
    int                k;
    cw = '0;
    k  = 0;
    for (int p = 1; p <= CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (k < DATA_W) begin
          cw[p-1] = data[k];
        end
        k++;
      end
    end
    return cw;
  endfunction

  // XOR of the positions of all set bits.
  function automatic logic [SYN_W-1:0] syndrome(input logic [CODE_W-1:0] word);
    logic [SYN_W-1:0] s;
    s = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      if (word[p-1]) begin
        s = s ^ SYN_W'(p);
      end
    end
    return s;
  endfunction

  typedef struct packed {
    logic [DATA_W-1:0] dmask;
    logic [CODE_W-1:0] cmask;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] data;
    logic [CODE_W-1:0] rx;
  } s1_t;

  typedef struct packed {
    logic              action;
    logic [CODE_W-1:0] word;
  } s2_t;

  typedef struct packed {
    logic              action;
    logic [CODE_W-1:0] word;
    logic [SYN_W-1:0]  syn;
  } s3_t;

endpackage

>>> rtl/core/hec_if.sv
// ---------------------------------------------------------------------------
// hec_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface hec_in_if;
  import hec_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [DATA_W-1:0] data_word;
  logic [CODE_W-1:0] received_word;

  modport source (output valid, action, data_word, received_word, input ready);
  modport sink   (input valid, action, data_word, received_word, output ready);
endinterface

interface hec_out_if;
  import hec_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] codeword;
  logic [SYN_W-1:0]  syndrome;
  logic              error_found;

  modport source (output valid, codeword, syndrome, error_found, input ready);
  modport sink   (input valid, codeword, syndrome, error_found, output ready);
endinterface

>>> rtl/core/hamming_encode_and_check_top.sv
// ---------------------------------------------------------------------------
// hamming_encode_and_check_top
// Hamming single-error encoder and syndrome checker, four-stage pipeline.
// ---------------------------------------------------------------------------
// Each request either encodes a data word (action 0) or checks a received
// codeword (action 1), and yields exactly one result. The code layout follows
// the data_length register (1..57 bits; 0 acts as 1, larger values clamp to
// 57): r parity bits sit at the power-of-two positions, data bits fill the
// rest LSB first, and bit 0 of every word is code position 1. The block takes
// one request per clock unless the output stalls, and passes each accepted
// request through the stages in order: input masking, codeword layout, the six
// syndrome XOR trees, and parity insertion into the output register. Each stage
// advances whenever its successor is free, so bubbles are squeezed out and a
// request is still accepted while a finished result waits at the output.
// Write data_length only while the pipeline is empty.
// ---------------------------------------------------------------------------
module hamming_encode_and_check_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [hec_pkg::LEN_W-1:0] cfg_wdata,
  hec_in_if.sink                    in_if,
  hec_out_if.source                 out_if
);
  import hec_pkg::*;

  cfg_t cfg;

  // Stage handshakes between the pipeline sections.
  logic s2_valid, s2_ready;
  s2_t  s2_data;
  logic s3_valid, s3_ready;
  s3_t  s3_data;

  // Hold the code layout derived from data_length.
  hec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Mask the request, then scatter data bits or pass the received word.
  hec_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg),
    .valid_i  (in_if.valid),
    .ready_o  (in_if.ready),
    .action_i (in_if.action),
    .data_i   (in_if.data_word),
    .rx_i     (in_if.received_word),
    .valid_o  (s2_valid),
    .ready_i  (s2_ready),
    .data_o   (s2_data)
  );

  // Compute the syndrome of the laid-out word.
  hec_syn u_syn (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  // Fill parity positions for encodes, report syndrome for checks.
  hec_fin u_fin (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (s3_valid),
    .ready_o    (s3_ready),
    .data_i     (s3_data),
    .valid_o    (out_if.valid),
    .ready_i    (out_if.ready),
    .codeword_o (out_if.codeword),
    .syndrome_o (out_if.syndrome),
    .error_o    (out_if.error_found)
  );
endmodule

>>> rtl/core/hec_cfg.sv
// ---------------------------------------------------------------------------
// hec_cfg
// Data-length register, held as the data and code masks it implies.
// ---------------------------------------------------------------------------
module hec_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hec_pkg::LEN_W-1:0]   cfg_wdata,
  output hec_pkg::cfg_t               cfg_o
);
  import hec_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [LEN_W-1:0] m_eff;

  always_comb begin
    m_eff         = eff_len(cfg_wdata);
    cfg_nxt.dmask = data_mask(m_eff);
    cfg_nxt.cmask = code_mask(m_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dmask <= data_mask(LEN_RESET);
      cfg_r.cmask <= code_mask(LEN_RESET);
    end else if (cfg_we) begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;
endmodule

>>> rtl/core/hec_prep.sv
// ---------------------------------------------------------------------------
// hec_prep
// Stages 1-2: mask the request to the code length, then lay out the word.
// ---------------------------------------------------------------------------
module hec_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  hec_pkg::cfg_t       cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic                action_i,
  input  logic [hec_pkg::DATA_W-1:0] data_i,
  input  logic [hec_pkg::CODE_W-1:0] rx_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hec_pkg::s2_t        data_o
);
  import hec_pkg::*;

  logic v1_r, v2_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic adv1, adv2;

  assign adv2    = !v2_r || ready_i;
  assign adv1    = !v1_r || adv2;
  assign ready_o = adv1;

  always_comb begin
    s1_nxt.action = action_i;
    s1_nxt.data   = data_i & cfg_i.dmask;
    s1_nxt.rx     = rx_i & cfg_i.cmask;
    s2_nxt.action = s1_r.action;
    s2_nxt.word   = (s1_r.action == ACT_CHECK) ? s1_r.rx : scatter(s1_r.data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= valid_i;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && valid_i) s1_r <= s1_nxt;
    if (adv2 && v1_r)    s2_r <= s2_nxt;
  end

  assign valid_o = v2_r;
  assign data_o  = s2_r;
endmodule

>>> rtl/core/hec_syn.sv
// ---------------------------------------------------------------------------
// hec_syn
// Stage 3: syndrome XOR trees over the laid-out word.
// ---------------------------------------------------------------------------
module hec_syn (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  hec_pkg::s2_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hec_pkg::s3_t  data_o
);
  import hec_pkg::*;

  logic v_r;
  s3_t  s_r, s_nxt;
  logic adv;

  assign adv     = !v_r || ready_i;
  assign ready_o = adv;

  always_comb begin
    s_nxt.action = data_i.action;
    s_nxt.word   = data_i.word;
    s_nxt.syn    = syndrome(data_i.word);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) s_r <= s_nxt;
  end

  assign valid_o = v_r;
  assign data_o  = s_r;
endmodule

>>> rtl/core/hec_fin.sv
// ---------------------------------------------------------------------------
// hec_fin
// Stage 4: insert parity bits or report the check, into the output register.
// ---------------------------------------------------------------------------
module hec_fin (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  hec_pkg::s3_t               data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [hec_pkg::CODE_W-1:0] codeword_o,
  output logic [hec_pkg::SYN_W-1:0]  syndrome_o,
  output logic                       error_o
);
  import hec_pkg::*;

  logic              v_r;
  logic [CODE_W-1:0] cw_r, cw_nxt;
  logic [SYN_W-1:0]  syn_r, syn_nxt;
  logic              err_r, err_nxt;
  logic              adv;

  assign adv     = !v_r || ready_i;
  assign ready_o = adv;

  always_comb begin
    cw_nxt  = '0;
    syn_nxt = '0;
    err_nxt = 1'b0;
    if (data_i.action == ACT_ENCODE) begin
      cw_nxt = data_i.word;
      // Parity position 2^i takes syndrome bit i.
      for (int i = 0; i < SYN_W; i++) begin
        cw_nxt[(1 << i) - 1] = data_i.syn[i];
      end
    end else begin
      syn_nxt = data_i.syn;
      err_nxt = |data_i.syn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      cw_r  <= cw_nxt;
      syn_r <= syn_nxt;
      err_r <= err_nxt;
    end
  end

  assign valid_o    = v_r;
  assign codeword_o = cw_r;
  assign syndrome_o = syn_r;
  assign error_o    = err_r;
endmodule

>>> rtl/core/hec_chk.sv
// ---------------------------------------------------------------------------
// hec_chk
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hec_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hec_pkg::CODE_W-1:0] codeword,
  input logic [hec_pkg::SYN_W-1:0]  syndrome,
  input logic                       error_found
);
  import hec_pkg::*;

  `HEC_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `HEC_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(codeword) && $stable(syndrome), "result changed while stalled")
  `HEC_ASSERT_NOW(a_err_syn, out_valid, error_found == (syndrome != '0), "error flag disagrees with syndrome")
  `HEC_ASSERT_NOW(a_err_cw, out_valid && error_found, codeword == '0, "check result carries a codeword")

endmodule

bind hamming_encode_and_check_top hec_chk u_hec_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .codeword    (out_if.codeword),
  .syndrome    (out_if.syndrome),
  .error_found (out_if.error_found)
);

>>> sim/hamming_encode_and_check_top_tb.sv
// ---------------------------------------------------------------------------
// hamming_encode_and_check_top_tb
// Self-checking bench for the Hamming encoder and syndrome checker. Requests
// (encode or check) stream through valid/ready channels across a series of
// data_length settings. A built-in predictor computes each expected codeword,
// syndrome and error flag, and every result is compared in order.
// ---------------------------------------------------------------------------
module hamming_encode_and_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hec_pkg::*;

  localparam int PIPE_DEPTH  = 4;       // pipeline stages from request to result
  localparam int CYCLE_LIMIT = 200000;  // generous bound on the whole run
  localparam int PHASE_ITEMS = 104;     // random requests per length setting
  localparam int HOLD_CYCLES = 150;     // one long receiver hold-off
  localparam int IDLE_PCT    = 13;

  typedef struct {
    logic              action;
    logic [DATA_W-1:0] data;
    logic [CODE_W-1:0] rx;
  } request_t;

  typedef struct {
    logic [CODE_W-1:0] codeword;
    logic [SYN_W-1:0]  syndrome;
    logic              error_found;
  } coded_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  hec_in_if  in_bus ();
  hec_out_if out_bus ();

  hamming_encode_and_check_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_bus),
    .out_if    (out_bus)
  );

  // Requests waiting to be offered, and results still owed by the block.
  request_t      pending_reqs[$];
  coded_result_t results_due[$];

  logic [LEN_W-1:0] len_mirror;    // data_length as the block holds it
  int unsigned      taken_count;   // requests accepted so far
  int unsigned      fault_count;

  // Both sides drop idling inside this window of accepted requests.
  function automatic bit quiet_window();
    return taken_count >= 300 && taken_count < 560;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Smallest parity count r with 2^r >= m + r + 1.
  function automatic int check_bits_for(input int m);
    int r;
    r = 0;
    while (r < 7 && (1 << r) < m + r + 1) r++;
    return r;
  endfunction

  // Data length actually used: zero acts as one, and oversized lengths shrink
  // until the whole code fits in the widest word.
  function automatic int data_bits_for(input logic [LEN_W-1:0] len);
    int m;
    m = (len == '0) ? 1 : int'(len);
    while (m > 1 && m + check_bits_for(m) > MAX_CODE_BITS) m--;
    return m;
  endfunction

  // XOR of the code positions (1-based) of every set bit.
  function automatic logic [SYN_W-1:0] position_xor(input logic [CODE_W-1:0] word);
    logic [SYN_W-1:0] acc;
    acc = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      if (word[p-1]) acc ^= SYN_W'(p);
    end
    return acc;
  endfunction

  function automatic coded_result_t predict_result(input request_t rq,
                                                   input logic [LEN_W-1:0] len);
    coded_result_t    res;
    int               m;
    int               r;
    int               n;
    int               k;
    logic [CODE_W-1:0] word;
    logic [SYN_W-1:0]  parity;
    m = data_bits_for(len);
    r = check_bits_for(m);
    n = m + r;
    res.codeword    = '0;
    res.syndrome    = '0;
    res.error_found = 1'b0;
    if (rq.action == ACT_ENCODE) begin
      // Scatter data into the non-power-of-two slots, then fill each parity
      // slot so that its group XORs to zero.
      word = '0;
      k    = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          word[p-1] = rq.data[k];
          k++;
        end
      end
      parity = position_xor(word);
      for (int i = 0; i < r; i++) word[(1 << i) - 1] = parity[i];
      res.codeword = word;
    end else begin
      word            = rq.rx & ({CODE_W{1'b1}} >> (CODE_W - n));
      res.syndrome    = position_xor(word);
      res.error_found = (res.syndrome != '0);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, and the watchdog that bounds the run
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("hamming_encode_and_check_top verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge. Once valid is up, hold
  // it and the payload until the monitor has seen the handshake.
  // --------------------------------------------------------------------------
  int unsigned seen_taken;

  always @(negedge clk) begin : request_driver
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && taken_count == seen_taken) begin
      // hold the current request
    end else begin
      seen_taken = taken_count;
      if (pending_reqs.size() != 0 &&
          (quiet_window() || $urandom_range(99) >= IDLE_PCT)) begin
        in_bus.valid         <= 1'b1;
        in_bus.action        <= pending_reqs[0].action;
        in_bus.data_word     <= pending_reqs[0].data;
        in_bus.received_word <= pending_reqs[0].rx;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off while the driver
  // keeps offering, so the pipeline backs up and ready drops on the input.
  // --------------------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_done;

  always @(negedge clk) begin : result_receiver
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && taken_count >= 800) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= quiet_window() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge. Check the result first,
  // then record the request accepted at this edge, so a result can never be
  // matched against a prediction made in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    coded_result_t want;
    request_t      seen;
    if (!rst_n) begin
      len_mirror = LEN_RESET;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (results_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          fault_count++;
        end else begin
          want = results_due.pop_front();
          if (out_bus.codeword !== want.codeword) begin
            $error("codeword: expected %h, got %h", want.codeword, out_bus.codeword);
            fault_count++;
          end
          if (out_bus.syndrome !== want.syndrome) begin
            $error("syndrome: expected %0d, got %0d", want.syndrome, out_bus.syndrome);
            fault_count++;
          end
          if (out_bus.error_found !== want.error_found) begin
            $error("error_found: expected %b, got %b",
                   want.error_found, out_bus.error_found);
            fault_count++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        // Predict from what was really on the bus, then advance the queue.
        seen.action = in_bus.action;
        seen.data   = in_bus.data_word;
        seen.rx     = in_bus.received_word;
        results_due.push_back(predict_result(seen, len_mirror));
        void'(pending_reqs.pop_front());
        taken_count++;
      end
      // Writes only land while idle, so the order against prediction is moot.
      if (cfg_we) len_mirror = cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_encode(input logic [DATA_W-1:0] data);
    request_t rq;
    rq.action = ACT_ENCODE;
    rq.data   = data;
    rq.rx     = CODE_W'({$urandom, $urandom});
    pending_reqs.push_back(rq);
  endtask

  task automatic queue_check(input logic [CODE_W-1:0] rx);
    request_t rq;
    rq.action = ACT_CHECK;
    rq.data   = DATA_W'({$urandom, $urandom});
    rq.rx     = rx;
    pending_reqs.push_back(rq);
  endtask

  // Random request for the given length. Most checks carry a proper codeword
  // with zero, one or two flipped bits; the rest are raw noise.
  task automatic queue_random(input logic [LEN_W-1:0] len);
    request_t      rq;
    request_t      src;
    coded_result_t enc;
    int            n;
    int            pick;
    int            p1;
    int            p2;
    logic [CODE_W-1:0] in_code;
    rq.action = $urandom_range(1) ? ACT_CHECK : ACT_ENCODE;
    rq.data   = DATA_W'({$urandom, $urandom});
    rq.rx     = CODE_W'({$urandom, $urandom});
    if (rq.action == ACT_CHECK) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        src.action = ACT_ENCODE;
        src.data   = DATA_W'({$urandom, $urandom});
        src.rx     = '0;
        enc        = predict_result(src, len);
        n          = data_bits_for(len) + check_bits_for(data_bits_for(len));
        in_code    = {CODE_W{1'b1}} >> (CODE_W - n);
        // Sometimes leave garbage above the code length; it must be ignored.
        rq.rx = enc.codeword | ($urandom_range(1) ? (rq.rx & ~in_code) : '0);
        p1    = $urandom_range(n - 1);
        p2    = (p1 + 1 + $urandom_range(n - 2)) % n;
        if (pick >= 25) rq.rx[p1] = ~rq.rx[p1];
        if (pick >= 65) rq.rx[p2] = ~rq.rx[p2];
      end
    end
    pending_reqs.push_back(rq);
  endtask

  // Wait until every request is taken and answered, then let the pipeline
  // settle before anything touches the length register.
  task automatic drain_requests();
    while (pending_reqs.size() != 0 || results_due.size() != 0) @(negedge clk);
    repeat (2 * PIPE_DEPTH) @(negedge clk);
  endtask

  // Pulse the write enable for one cycle, then step to a rising edge so new
  // requests are queued away from the driver's edge.
  task automatic write_length(input logic [LEN_W-1:0] len);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int plan[$];
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_bus.valid         = 1'b0;
    in_bus.action        = ACT_ENCODE;
    in_bus.data_word     = '0;
    in_bus.received_word = '0;
    out_bus.ready        = 1'b0;
    taken_count          = 0;
    seen_taken           = 0;
    fault_count          = 0;
    hold_left            = 0;
    hold_done            = 1'b0;
    len_mirror           = LEN_RESET;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset length (4 data bits, 7-bit code): zero and all-ones words both
    // ways, a sample word, and a single error at position 5.
    queue_encode('0);
    queue_encode('1);
    queue_encode(DATA_W'(4'b1011));
    queue_check('0);
    queue_check('1);
    queue_check(CODE_W'(1) << 4);
    drain_requests();

    // Five data bits, 9-bit code: errors at positions 2 and 8 give syndrome
    // 10, beyond the code length, which must still be reported.
    write_length(LEN_W'(5));
    queue_check((CODE_W'(1) << 1) | (CODE_W'(1) << 7));
    queue_encode('1);
    drain_requests();

    // Zero length acts as one data bit; data above that bit is ignored.
    write_length(LEN_W'(0));
    queue_encode('1);
    queue_check('1);
    drain_requests();

    // Oversized length clamps to the widest code; position 63 alone gives
    // the largest syndrome.
    write_length(LEN_W'(63));
    queue_encode('1);
    queue_check('1);
    queue_check(CODE_W'(1) << 62);
    drain_requests();

    write_length(LEN_W'(57));
    queue_encode(DATA_W'({(DATA_W + 1) / 2{2'b01}}));
    queue_check('0);
    drain_requests();

    write_length(LEN_W'(1));
    queue_encode(DATA_W'(1));
    queue_check(CODE_W'(4));
    drain_requests();

    // Random phases: the edge lengths first, then a few picked at random.
    plan = '{1, 2, 3, 57, 58, 63, 0, 4, 11, 26};
    repeat (4) plan.push_back($urandom_range(63));
    foreach (plan[i]) begin
      write_length(LEN_W'(plan[i]));
      repeat (PHASE_ITEMS) queue_random(LEN_W'(plan[i]));
      drain_requests();
    end

    if (fault_count == 0 && results_due.size() == 0) begin
      $display("hamming_encode_and_check_top verification clean");
    end else begin
      $display("hamming_encode_and_check_top verification failed");
    end
    $finish;
  end

endmodule
